FILE: src/otca_pkg.sv
// Shared types, codes and constants for the one-time code authorizer.
`default_nettype none
package otca_pkg;

    localparam int CODE_W     = 20;
    localparam int CHARS_W    = 48;
    localparam int CHARS_N    = CHARS_W / 8;
    localparam int LEN_W      = 3;
    localparam int TTL_W      = 24;
    localparam int ATT_W      = 8;
    localparam int ACT_W      = 3;
    localparam int MODE_W     = 3;
    localparam int STAT_W     = 3;
    localparam int CFG_IDX_W  = 1;

    localparam int CODE_DIGITS_DEF = 6;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [TTL_W-1:0] TTL_RESET     = 24'd300000;
    localparam logic [ATT_W-1:0] MAX_ATT_RESET = 8'd5;
    localparam logic [ATT_W-1:0] FAIL_MAX      = 8'd255;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TTL_MS       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 1'b1;

    // actions
    localparam logic [ACT_W-1:0] ACT_TICK        = 3'd0;
    localparam logic [ACT_W-1:0] ACT_GENERATE    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_CANCEL      = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CONSUME     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_MARK_RUN    = 3'd4;
    localparam logic [ACT_W-1:0] ACT_START_FAIL  = 3'd5;
    localparam logic [ACT_W-1:0] ACT_UPDATE_FAIL = 3'd6;

    // modes
    localparam logic [MODE_W-1:0] MODE_DISABLED     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_AVAILABLE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOCKED       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_EXPIRED      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CONSUMED     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RUNNING      = 3'd5;
    localparam logic [MODE_W-1:0] MODE_START_FAILED = 3'd6;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
    localparam logic [STAT_W-1:0] ST_INVALID     = 3'd1;
    localparam logic [STAT_W-1:0] ST_RNG_FAIL    = 3'd2;
    localparam logic [STAT_W-1:0] ST_ACCEPTED    = 3'd3;
    localparam logic [STAT_W-1:0] ST_REJECTED    = 3'd4;
    localparam logic [STAT_W-1:0] ST_UNAVAILABLE = 3'd5;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [CODE_W-1:0]  new_code;
        logic               rng_valid;
        logic [CHARS_W-1:0] supplied_chars;
        logic [LEN_W-1:0]   supplied_len;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [MODE_W-1:0] code_state;
        logic [CODE_W-1:0] shown_code;
        logic [ATT_W-1:0]  attempts_left;
        logic [TTL_W-1:0]  ms_left;
    } out_item_t;

    // classified command handed from front to back
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [CODE_W-1:0] new_code;
        logic              rng_ok;
        logic              form_ok;
        logic [CODE_W-1:0] code_val;
    } cmd_t;

    // elaboration-time power of ten
    function automatic logic [63:0] pow10(input int n);
        logic [63:0] r;
        r = 64'd1;
        for (int i = 0; i < n; i++) begin
            r = r * 64'd10;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: src/otca_front.sv
// Front end: checks the random value and decodes the supplied digit string.
`default_nettype none
module otca_front #(
    parameter int CODE_DIGITS = otca_pkg::CODE_DIGITS_DEF
) (
    input  wire otca_pkg::in_item_t item,
    output otca_pkg::cmd_t          cmd
);

    localparam logic [63:0] RANGE = otca_pkg::pow10(CODE_DIGITS);
    localparam int          VAL_W = $clog2(RANGE);

    logic [CODE_DIGITS-1:0] is_digit;
    logic [VAL_W-1:0]       term [CODE_DIGITS];
    logic [VAL_W-1:0]       value;
    logic                   len_ok;

    genvar gi;
    generate
        for (gi = 0; gi < CODE_DIGITS; gi++) begin : g_digit
            localparam int BYTE_POS = CODE_DIGITS - 1 - gi;
            localparam logic [63:0] WEIGHT = otca_pkg::pow10(CODE_DIGITS - 1 - gi);
            if (BYTE_POS < otca_pkg::CHARS_N) begin : g_in
                logic [7:0] ch;
                assign ch = item.supplied_chars[8*BYTE_POS +: 8];
                assign is_digit[gi] = (ch >= otca_pkg::CHAR_ZERO) &&
                                      (ch <= otca_pkg::CHAR_NINE);
                // low nibble of an ASCII digit is its value
                assign term[gi] = VAL_W'(ch[3:0]) * VAL_W'(WEIGHT);
            end else begin : g_out
                // beyond the character field: never a digit
                assign is_digit[gi] = 1'b0;
                assign term[gi] = '0;
            end
        end
    endgenerate

    always_comb begin
        value = '0;
        for (int i = 0; i < CODE_DIGITS; i++) begin
            value = value + term[i];
        end
    end

    assign len_ok = (32'(item.supplied_len) == CODE_DIGITS);

    assign cmd.action   = item.action;
    assign cmd.new_code = item.new_code;
    assign cmd.rng_ok   = item.rng_valid && (64'(item.new_code) < RANGE);
    // a value that cannot fit the stored code can never match
    assign cmd.form_ok  = len_ok && (&is_digit) &&
                          (64'(value) < (64'd1 << otca_pkg::CODE_W));
    assign cmd.code_val = otca_pkg::CODE_W'(value);

endmodule
`default_nettype wire

FILE: src/otca_fifo.sv
// Short command queue between the front end and the execution back end.
`default_nettype none
module otca_fifo #(
    parameter int DEPTH = otca_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  push,
    input  wire otca_pkg::cmd_t  push_data,
    output logic                 full,
    input  wire                  pop,
    output logic                 head_valid,
    output otca_pkg::cmd_t       head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    otca_pkg::cmd_t   storage_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = storage_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            storage_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

FILE: src/otca_back.sv
// Back end: guard state, configuration registers and the result register.
`default_nettype none
module otca_back (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_wen,
    input  wire [otca_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [otca_pkg::TTL_W-1:0]         cfg_wdata,
    input  wire                               head_valid,
    input  wire otca_pkg::cmd_t               head,
    output logic                              pop,
    output logic                              m_valid,
    input  wire                               m_ready,
    output otca_pkg::out_item_t               m_data
);

    logic [otca_pkg::TTL_W-1:0]  ttl_reg;
    logic [otca_pkg::ATT_W-1:0]  max_att_reg;
    logic [otca_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [otca_pkg::CODE_W-1:0] code_reg, code_next;
    logic [otca_pkg::ATT_W-1:0]  fail_reg, fail_next;
    logic [otca_pkg::TTL_W-1:0]  cd_reg, cd_next;
    logic                        m_valid_reg;
    otca_pkg::out_item_t         m_data_reg, m_data_next;
    logic [otca_pkg::STAT_W-1:0] status;
    logic                        live, live_next, busy;
    logic [otca_pkg::ATT_W-1:0]  fail_sat;

    assign pop     = head_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        mode_next = mode_reg;
        code_next = code_reg;
        fail_next = fail_reg;
        cd_next   = cd_reg;
        status    = otca_pkg::ST_OK;
        fail_sat  = fail_reg;

        live = (mode_reg == otca_pkg::MODE_AVAILABLE) || (mode_reg == otca_pkg::MODE_LOCKED);
        if (head.action == otca_pkg::ACT_TICK && live && cd_reg != '0) begin
            cd_next = cd_reg - otca_pkg::TTL_W'(1);
        end
        // rotation when the countdown has run out
        if (live && cd_next == '0) begin
            fail_next = '0;
            if (head.rng_ok) begin
                code_next = head.new_code;
                cd_next   = ttl_reg;
                mode_next = otca_pkg::MODE_AVAILABLE;
            end else begin
                code_next = '0;
                mode_next = otca_pkg::MODE_EXPIRED;
            end
        end
        busy = (mode_next == otca_pkg::MODE_CONSUMED) || (mode_next == otca_pkg::MODE_RUNNING);

        case (head.action)
            otca_pkg::ACT_TICK: begin
            end
            otca_pkg::ACT_GENERATE: begin
                if (!head.rng_ok) begin
                    status = otca_pkg::ST_RNG_FAIL;
                end else if (busy) begin
                    status = otca_pkg::ST_INVALID;
                end else begin
                    code_next = head.new_code;
                    fail_next = '0;
                    cd_next   = ttl_reg;
                    mode_next = otca_pkg::MODE_AVAILABLE;
                end
            end
            otca_pkg::ACT_CANCEL: begin
                if (!busy) begin
                    code_next = '0;
                    mode_next = otca_pkg::MODE_DISABLED;
                    cd_next   = '0;
                    fail_next = '0;
                end
            end
            otca_pkg::ACT_CONSUME: begin
                if (mode_next != otca_pkg::MODE_AVAILABLE) begin
                    status = otca_pkg::ST_UNAVAILABLE;
                end else if (head.form_ok && head.code_val == code_next) begin
                    code_next = '0;
                    cd_next   = '0;
                    mode_next = otca_pkg::MODE_CONSUMED;
                    status    = otca_pkg::ST_ACCEPTED;
                end else begin
                    fail_sat  = (fail_next != otca_pkg::FAIL_MAX) ?
                                fail_next + otca_pkg::ATT_W'(1) : fail_next;
                    fail_next = fail_sat;
                    if (fail_sat >= max_att_reg) begin
                        code_next = '0;
                        mode_next = otca_pkg::MODE_LOCKED;
                    end
                    status = otca_pkg::ST_REJECTED;
                end
            end
            otca_pkg::ACT_MARK_RUN: begin
                if (mode_next == otca_pkg::MODE_CONSUMED) begin
                    mode_next = otca_pkg::MODE_RUNNING;
                end
            end
            otca_pkg::ACT_START_FAIL: begin
                if (busy) begin
                    mode_next = otca_pkg::MODE_START_FAILED;
                end
            end
            otca_pkg::ACT_UPDATE_FAIL: begin
                if (mode_next == otca_pkg::MODE_RUNNING) begin
                    mode_next = otca_pkg::MODE_START_FAILED;
                end
            end
            default: begin
                status = otca_pkg::ST_INVALID;
            end
        endcase

        live_next = (mode_next == otca_pkg::MODE_AVAILABLE) ||
                    (mode_next == otca_pkg::MODE_LOCKED);
        m_data_next.status     = status;
        m_data_next.code_state = mode_next;
        m_data_next.shown_code = (mode_next == otca_pkg::MODE_AVAILABLE) ? code_next : '0;
        m_data_next.attempts_left =
            (mode_next == otca_pkg::MODE_AVAILABLE && max_att_reg > fail_next) ?
            max_att_reg - fail_next : '0;
        m_data_next.ms_left = live_next ? cd_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ttl_reg     <= otca_pkg::TTL_RESET;
            max_att_reg <= otca_pkg::MAX_ATT_RESET;
        end else if (cfg_wen) begin
            if (cfg_index == otca_pkg::CFG_TTL_MS) begin
                ttl_reg <= cfg_wdata;
            end else if (cfg_index == otca_pkg::CFG_MAX_ATTEMPTS) begin
                max_att_reg <= cfg_wdata[otca_pkg::ATT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= otca_pkg::MODE_DISABLED;
            code_reg    <= '0;
            fail_reg    <= '0;
            cd_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                mode_reg <= mode_next;
                code_reg <= code_next;
                fail_reg <= fail_next;
                cd_reg   <= cd_next;
            end
            if (pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= m_data_next;
        end
    end

`ifndef NO_ASSERTIONS
    // the code is only held while available
    a_code_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg != otca_pkg::MODE_AVAILABLE |-> code_reg == '0)
        else $error("stored code kept outside available mode");

    // an accepted consume always leaves the guard consumed
    a_accept_consumed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.status == otca_pkg::ST_ACCEPTED
        |-> m_data_reg.code_state == otca_pkg::MODE_CONSUMED)
        else $error("accepted transaction without consumed state");

    // a pending result is never overwritten by a new transaction
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !pop)
        else $error("queue popped while result stalled");

    // state moves only when a command leaves the queue
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !pop |=> $stable(mode_reg) && $stable(cd_reg))
        else $error("guard state changed without a command");
`endif

endmodule
`default_nettype wire

FILE: src/one_time_code_authorizer.sv
// Order: an accepted transaction is written into the queue; the back end pops it
//   when the output is free and registers its result; results stay in order.
// Throughput: one transaction per cycle while m_ready holds, set by the back end;
//   a QUEUE_DEPTH-entry queue plus the output register absorb stalls.
// Reset: synchronous, active low; mode disabled, code, failures and countdown zero,
//   ttl_ms 300000, max_attempts 5; no clearing pass, ready right after reset.
`default_nettype none
module one_time_code_authorizer #(
    parameter int CODE_DIGITS = otca_pkg::CODE_DIGITS_DEF,
    parameter int QUEUE_DEPTH = otca_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_wen,
    input  wire [otca_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [otca_pkg::TTL_W-1:0]         cfg_wdata,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire otca_pkg::in_item_t           s_data,
    output logic                              m_valid,
    input  wire                               m_ready,
    output otca_pkg::out_item_t               m_data
);

    otca_pkg::cmd_t front_cmd;
    otca_pkg::cmd_t head;
    logic           full;
    logic           head_valid;
    logic           pop;
    logic           push;

    assign s_ready = !full;
    assign push    = s_valid && !full;

    otca_front #(
        .CODE_DIGITS(CODE_DIGITS)
    ) u_front (
        .item(s_data),
        .cmd (front_cmd)
    );

    otca_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_cmd),
        .full      (full),
        .pop       (pop),
        .head_valid(head_valid),
        .head      (head)
    );

    otca_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .head_valid(head_valid),
        .head      (head),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

FILE: sim/one_time_code_authorizer_tb.sv
// Self-checking testbench for the one-time code authorizer: directed and random commands.
`timescale 1ns / 100ps
module one_time_code_authorizer_tb;
    import otca_pkg::*;

    localparam int               CODE_DIGITS   = CODE_DIGITS_DEF;
    localparam int unsigned      CODE_SPAN     = 1000000;
    localparam int unsigned      CODE_FIELD_MAX = (1 << CODE_W) - 1;
    localparam logic [ACT_W-1:0] ACT_UNDEFINED = 3'd7;
    localparam int               PHASES        = 6;
    localparam int               PHASE_ITEMS   = 92;

    // Tracks the guard state and holds the snapshots still owed by the block.
    class guard_tracker;
        logic [TTL_W-1:0]  ttl_ms;
        logic [ATT_W-1:0]  max_attempts;
        logic [MODE_W-1:0] mode;
        logic [CODE_W-1:0] code;
        logic [ATT_W-1:0]  fails;
        logic [TTL_W-1:0]  countdown;
        out_item_t         snapshots_due[$];
        int                bad_results;
        int                results_seen;

        function new();
            ttl_ms       = TTL_RESET;
            max_attempts = MAX_ATT_RESET;
            mode         = MODE_DISABLED;
            code         = '0;
            fails        = '0;
            countdown    = '0;
            bad_results  = 0;
            results_seen = 0;
        endfunction

        function bit typed_code_ok(in_item_t it);
            int unsigned value;
            logic [7:0]  ch;
            value = 0;
            if (it.supplied_len != LEN_W'(CODE_DIGITS)) return 1'b0;
            for (int i = 0; i < CODE_DIGITS; i++) begin
                ch = it.supplied_chars[8*(CODE_DIGITS-1-i) +: 8];
                if (ch < CHAR_ZERO || ch > CHAR_NINE) return 1'b0;
                value = value * 10 + (ch - CHAR_ZERO);
            end
            return value == code;
        endfunction

        function void take_command(in_item_t it);
            out_item_t         snap;
            logic [STAT_W-1:0] status;
            bit                rng_ok;
            bit                live;
            bit                busy;
            status = ST_OK;
            rng_ok = it.rng_valid && (it.new_code < CODE_SPAN);
            live   = (mode == MODE_AVAILABLE || mode == MODE_LOCKED);
            if (it.action == ACT_TICK && live && countdown != 0) countdown--;
            // expiry rotation happens before the action itself
            if (live && countdown == 0) begin
                fails = '0;
                if (rng_ok) begin
                    code      = it.new_code;
                    countdown = ttl_ms;
                    mode      = MODE_AVAILABLE;
                end else begin
                    code = '0;
                    mode = MODE_EXPIRED;
                end
            end
            busy = (mode == MODE_CONSUMED || mode == MODE_RUNNING);
            case (it.action)
                ACT_TICK: ;
                ACT_GENERATE: begin
                    if (!rng_ok) begin
                        status = ST_RNG_FAIL;
                    end else if (busy) begin
                        status = ST_INVALID;
                    end else begin
                        code      = it.new_code;
                        fails     = '0;
                        countdown = ttl_ms;
                        mode      = MODE_AVAILABLE;
                    end
                end
                ACT_CANCEL: begin
                    if (!busy) begin
                        code      = '0;
                        mode      = MODE_DISABLED;
                        countdown = '0;
                        fails     = '0;
                    end
                end
                ACT_CONSUME: begin
                    if (mode != MODE_AVAILABLE) begin
                        status = ST_UNAVAILABLE;
                    end else if (typed_code_ok(it)) begin
                        code      = '0;
                        countdown = '0;
                        mode      = MODE_CONSUMED;
                        status    = ST_ACCEPTED;
                    end else begin
                        if (fails != FAIL_MAX) fails++;
                        if (fails >= max_attempts) begin
                            code = '0;
                            mode = MODE_LOCKED;
                        end
                        status = ST_REJECTED;
                    end
                end
                ACT_MARK_RUN: begin
                    if (mode == MODE_CONSUMED) mode = MODE_RUNNING;
                end
                ACT_START_FAIL: begin
                    if (busy) mode = MODE_START_FAILED;
                end
                ACT_UPDATE_FAIL: begin
                    if (mode == MODE_RUNNING) mode = MODE_START_FAILED;
                end
                default: status = ST_INVALID;
            endcase
            snap.status        = status;
            snap.code_state    = mode;
            snap.shown_code    = (mode == MODE_AVAILABLE) ? code : '0;
            snap.attempts_left = (mode == MODE_AVAILABLE && max_attempts > fails)
                                 ? max_attempts - fails : '0;
            snap.ms_left       = (mode == MODE_AVAILABLE || mode == MODE_LOCKED)
                                 ? countdown : '0;
            snapshots_due.push_back(snap);
        endfunction

        function void check_snapshot(out_item_t got);
            out_item_t want;
            results_seen++;
            if (snapshots_due.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("ERROR: result %0d arrived with nothing outstanding: %h",
                             results_seen, got);
                return;
            end
            want = snapshots_due.pop_front();
            if (got.status !== want.status || got.code_state !== want.code_state ||
                got.shown_code !== want.shown_code ||
                got.attempts_left !== want.attempts_left ||
                got.ms_left !== want.ms_left) begin
                bad_results++;
                if (bad_results <= 10) begin
                    $write("ERROR: result %0d (expected/actual): status %0d/%0d state %0d/%0d ",
                           results_seen, want.status, got.status,
                           want.code_state, got.code_state);
                    $display("code %0d/%0d attempts %0d/%0d ms %0d/%0d",
                             want.shown_code, got.shown_code,
                             want.attempts_left, got.attempts_left,
                             want.ms_left, got.ms_left);
                end
            end
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TTL_W-1:0]     cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;

    bit           calm       = 1'b0;
    int           stall_left = 0;
    guard_tracker tracker    = new();

    int unsigned  phase_ttl[PHASES]  = '{3, 1, 16777215, 6, 0, 300000};
    int unsigned  phase_att[PHASES]  = '{3, 1, 255, 2, 4, 5};
    bit           phase_calm[PHASES] = '{0, 0, 0, 1, 0, 0};

    one_time_code_authorizer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #5 aclk = ~aclk;

    function automatic int idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [CHARS_W-1:0] as_text(int unsigned v);
        logic [CHARS_W-1:0] t;
        for (int i = 0; i < CHARS_N; i++) begin
            t[8*i +: 8] = CHAR_ZERO + 8'(v % 10);
            v = v / 10;
        end
        return t;
    endfunction

    function automatic in_item_t cmd(logic [ACT_W-1:0] action, int unsigned value,
                                     bit rng, logic [CHARS_W-1:0] chars,
                                     logic [LEN_W-1:0] len);
        in_item_t it;
        it.action         = action;
        it.new_code       = CODE_W'(value);
        it.rng_valid      = rng;
        it.supplied_chars = chars;
        it.supplied_len   = len;
        return it;
    endfunction

    // Random command, biased by the tracked mode toward sequences that go deep.
    function automatic in_item_t make_command();
        in_item_t    it;
        int unsigned pick;
        int unsigned kind;
        int unsigned slot;
        logic [7:0]  junk;
        it.new_code = ($urandom_range(0, 9) == 0)
                      ? CODE_W'($urandom_range(CODE_SPAN, CODE_FIELD_MAX))
                      : CODE_W'($urandom_range(0, CODE_SPAN - 1));
        it.rng_valid      = ($urandom_range(0, 9) != 0);
        it.supplied_chars = {16'($urandom()), 32'($urandom())};
        it.supplied_len   = LEN_W'($urandom());
        pick = $urandom_range(0, 99);
        if (tracker.mode != MODE_AVAILABLE && tracker.mode != MODE_CONSUMED &&
            tracker.mode != MODE_RUNNING && $urandom_range(0, 2) == 0)
            pick = 35;
        if (pick < 30)      it.action = ACT_TICK;
        else if (pick < 45) it.action = ACT_GENERATE;
        else if (pick < 50) it.action = ACT_CANCEL;
        else if (pick < 78) it.action = ACT_CONSUME;
        else if (pick < 86) it.action = ACT_MARK_RUN;
        else if (pick < 91) it.action = ACT_START_FAIL;
        else if (pick < 96) it.action = ACT_UPDATE_FAIL;
        else                it.action = ACT_UNDEFINED;
        if (it.action == ACT_CONSUME) begin
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                it.supplied_chars = as_text(kind == 5
                    ? (int'(tracker.code) + $urandom_range(1, CODE_SPAN - 1)) % CODE_SPAN
                    : tracker.code);
                it.supplied_len = LEN_W'(CODE_DIGITS);
            end
            if (kind == 6)
                it.supplied_len = $urandom_range(0, 1) ? LEN_W'(7) : LEN_W'($urandom_range(0, 5));
            if (kind == 7) begin
                slot = $urandom_range(0, CHARS_N - 1);
                junk = $urandom_range(0, 255);
                if (junk >= CHAR_ZERO && junk <= CHAR_NINE) junk = junk + 8'd10;
                it.supplied_chars[8*slot +: 8] = junk;
            end
        end
        return it;
    endfunction

    task automatic push_command(input in_item_t it);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        tracker.take_command(it);
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic settle();
        s_valid <= 1'b0;
        while (tracker.snapshots_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_config(input logic [TTL_W-1:0] ttl, input logic [ATT_W-1:0] att);
        cfg_wen   <= 1'b1;
        cfg_index <= CFG_TTL_MS;
        cfg_wdata <= ttl;
        @(posedge aclk);
        cfg_index <= CFG_MAX_ATTEMPTS;
        cfg_wdata <= TTL_W'(att);
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        tracker.ttl_ms       = ttl;
        tracker.max_attempts = att;
    endtask

    // result sink with random backpressure
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40)
                                                             : $urandom_range(1, 3);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.check_snapshot(m_data);
    end

    initial begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default lifetime and attempt limit
        push_command(cmd(ACT_TICK, 0, 1, '0, '0));
        push_command(cmd(ACT_CONSUME, 0, 1, as_text(0), 3'd6));
        push_command(cmd(ACT_GENERATE, 123, 0, '0, '0));
        push_command(cmd(ACT_GENERATE, CODE_SPAN, 1, '0, '0));
        push_command(cmd(ACT_GENERATE, 999999, 1, '0, '0));
        push_command(cmd(ACT_CONSUME, 0, 1, as_text(999999), 3'd5));
        push_command(cmd(ACT_CONSUME, 0, 1, as_text(999999), 3'd7));
        push_command(cmd(ACT_CONSUME, 0, 1, 48'h3A3939393939, 3'd6));
        push_command(cmd(ACT_CONSUME, 0, 1, 48'h39393939392F, 3'd6));
        push_command(cmd(ACT_TICK, 0, 0, '1, 3'd7));
        push_command(cmd(ACT_CONSUME, 0, 1, as_text(999999), 3'd6));
        push_command(cmd(ACT_GENERATE, 77, 1, '0, '0));
        push_command(cmd(ACT_CANCEL, 0, 1, '0, '0));
        push_command(cmd(ACT_MARK_RUN, 0, 1, '0, '0));
        push_command(cmd(ACT_UPDATE_FAIL, 0, 1, '0, '0));
        push_command(cmd(ACT_GENERATE, 0, 1, '0, '0));
        push_command(cmd(ACT_CONSUME, 0, 1, as_text(0), 3'd6));
        push_command(cmd(ACT_START_FAIL, 0, 1, '0, '0));
        push_command(cmd(ACT_UNDEFINED, 5, 1, '0, '0));
        push_command(cmd(ACT_CANCEL, 0, 1, '0, '0));
        push_command(cmd(ACT_MARK_RUN, 0, 1, '0, '0));

        // zero lifetime rotates on the next transaction; zero limit locks at once
        settle();
        load_config('0, '0);
        push_command(cmd(ACT_GENERATE, 123456, 1, '0, '0));
        push_command(cmd(ACT_TICK, 654321, 1, '0, '0));
        push_command(cmd(ACT_CONSUME, 0, 1, as_text(1), 3'd6));
        push_command(cmd(ACT_TICK, 0, 0, '0, '0));

        // failures beyond a lowered limit
        settle();
        load_config(24'd2, 8'd5);
        push_command(cmd(ACT_GENERATE, 500000, 1, '0, '0));
        repeat (3) push_command(cmd(ACT_CONSUME, 0, 1, as_text(500001), 3'd6));
        settle();
        load_config(24'd2, 8'd2);
        push_command(cmd(ACT_TICK, 0, 1, '0, '0));
        push_command(cmd(ACT_CONSUME, 0, 1, as_text(1), 3'd6));
        push_command(cmd(ACT_TICK, 42, 1, '0, '0));

        for (int p = 0; p < PHASES; p++) begin
            settle();
            load_config(TTL_W'(phase_ttl[p]), ATT_W'(phase_att[p]));
            calm = phase_calm[p];
            repeat (PHASE_ITEMS) push_command(make_command());
        end
        calm = 1'b0;

        settle();
        repeat (10) @(posedge aclk);
        if (tracker.bad_results == 0 && tracker.snapshots_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
src/otca_pkg.sv
src/otca_front.sv
src/otca_fifo.sv
src/otca_back.sv
src/one_time_code_authorizer.sv
sim/one_time_code_authorizer_tb.sv
